@@ design/bfp_pkg.sv @@
// ----------------------------------------------------------------------------
// bfp_pkg
// Sizes, codes, memory port bundles and the character decoder shared by the
// Brainfuck processor modules.
// ----------------------------------------------------------------------------
package bfp_pkg;

  localparam int unsigned PROG_DEPTH  = 4096;
  localparam int unsigned TAPE_DEPTH  = 32768;
  localparam int unsigned STACK_DEPTH = 64;
  localparam int unsigned CELL_BITS   = 8;

  localparam int unsigned PROG_AW = $clog2(PROG_DEPTH);
  localparam int unsigned PC_W    = $clog2(PROG_DEPTH + 1);
  localparam int unsigned TAPE_AW = $clog2(TAPE_DEPTH);
  localparam int unsigned STK_AW  = $clog2(STACK_DEPTH);
  localparam int unsigned SD_W    = $clog2(STACK_DEPTH + 1);
  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned STAT_W  = 3;
  localparam int unsigned OP_W    = 3;

  localparam logic [CHAR_W-1:0] CH_RIGHT = 8'h3E;
  localparam logic [CHAR_W-1:0] CH_LEFT  = 8'h3C;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_OUT   = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_IN    = 8'h2C;
  localparam logic [CHAR_W-1:0] CH_OPEN  = 8'h5B;
  localparam logic [CHAR_W-1:0] CH_CLOSE = 8'h5D;

  typedef enum logic [OP_W-1:0] {
    OP_RIGHT = 3'd0,
    OP_LEFT  = 3'd1,
    OP_PLUS  = 3'd2,
    OP_MINUS = 3'd3,
    OP_OUT   = 3'd4,
    OP_IN    = 3'd5,
    OP_OPEN  = 3'd6,
    OP_CLOSE = 3'd7
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK        = 3'd0,
    STAT_HALT      = 3'd1,
    STAT_FULL      = 3'd2,
    STAT_OVERFLOW  = 3'd3,
    STAT_UNMATCHED = 3'd4
  } status_e;

  typedef enum logic [0:0] {
    REQ_LOAD = 1'b0,
    REQ_STEP = 1'b1
  } req_e;

  typedef struct packed {
    logic                hit;
    op_e                 op;
  } dec_t;

  typedef struct packed {
    logic                we;
    logic [PROG_AW-1:0]  waddr;
    logic [OP_W-1:0]     wdata;
    logic [PROG_AW-1:0]  raddr;
  } prog_port_t;

  typedef struct packed {
    logic                we;
    logic [TAPE_AW-1:0]  waddr;
    logic [CELL_BITS-1:0] wdata;
    logic [TAPE_AW-1:0]  raddr;
  } tape_port_t;

  typedef struct packed {
    logic                we;
    logic [STK_AW-1:0]   waddr;
    logic [PROG_AW-1:0]  wdata;
    logic [STK_AW-1:0]   raddr;
  } stk_port_t;

  function automatic dec_t decode_char(input logic [CHAR_W-1:0] c);
    dec_t d;
    d.hit = 1'b1;
    d.op  = OP_RIGHT;
    unique case (c)
      CH_RIGHT: d.op = OP_RIGHT;
      CH_LEFT:  d.op = OP_LEFT;
      CH_PLUS:  d.op = OP_PLUS;
      CH_MINUS: d.op = OP_MINUS;
      CH_OUT:   d.op = OP_OUT;
      CH_IN:    d.op = OP_IN;
      CH_OPEN:  d.op = OP_OPEN;
      CH_CLOSE: d.op = OP_CLOSE;
      default:  d.hit = 1'b0;
    endcase
    return d;
  endfunction

endpackage

@@ design/bfp_if.sv @@
// ----------------------------------------------------------------------------
// bfp_if
// Valid/ready channels of the Brainfuck processor: request and result.
// ----------------------------------------------------------------------------
interface bfp_in_if;
  import bfp_pkg::*;

  logic              valid;
  logic              ready;
  logic              req_type;
  logic [CHAR_W-1:0] prog_char;
  logic [CHAR_W-1:0] in_value;

  modport source (output valid, req_type, prog_char, in_value, input ready);
  modport sink   (input valid, req_type, prog_char, in_value, output ready);
endinterface

interface bfp_out_if;
  import bfp_pkg::*;

  logic              valid;
  logic              ready;
  logic              out_valid;
  logic [CHAR_W-1:0] out_value;
  logic              in_taken;
  logic [STAT_W-1:0] status;
  logic [PC_W-1:0]   pc_now;

  modport source (output valid, out_valid, out_value, in_taken, status, pc_now,
                  input ready);
  modport sink   (input valid, out_valid, out_value, in_taken, status, pc_now,
                  output ready);
endinterface

@@ design/bfp_ram.sv @@
// ----------------------------------------------------------------------------
// bfp_ram
// Generic single-clock RAM, one write port and one read port with a
// registered read.
// ----------------------------------------------------------------------------
module bfp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ design/bfp_ctrl.sv @@
// ----------------------------------------------------------------------------
// bfp_ctrl
// Sequencer of the Brainfuck processor: clears the tape after reset, appends
// program opcodes, and executes one instruction per step request by reading
// program, tape and loop stack and writing the results back.
// ----------------------------------------------------------------------------
module bfp_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  bfp_in_if.sink                    in_i,
  bfp_out_if.source                 out_o,
  output bfp_pkg::prog_port_t       prog_o,
  input  logic [bfp_pkg::OP_W-1:0]  prog_rdata_i,
  output bfp_pkg::tape_port_t       tape_o,
  input  logic [bfp_pkg::CELL_BITS-1:0] tape_rdata_i,
  output bfp_pkg::stk_port_t        stk_o,
  input  logic [bfp_pkg::PROG_AW-1:0] stk_rdata_i
);
  import bfp_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR = 3'b001,
    S_IDLE  = 3'b010,
    S_EXEC  = 3'b100
  } state_e;

  state_e               state_q, state_d;
  logic [TAPE_AW-1:0]   clr_q, clr_d;
  logic [PC_W-1:0]      cnt_q, cnt_d;
  logic [PC_W-1:0]      pc_q, pc_d;
  logic [TAPE_AW-1:0]   dp_q, dp_d;
  logic [SD_W-1:0]      sd_q, sd_d;
  logic [PC_W-1:0]      skip_q, skip_d;
  status_e              err_q, err_d;
  logic [CHAR_W-1:0]    inval_q, inval_d;

  logic                 ov_q, ov_d;
  logic                 o_outv_q, o_outv_d;
  logic [CHAR_W-1:0]    o_val_q, o_val_d;
  logic                 o_taken_q, o_taken_d;
  status_e              o_stat_q, o_stat_d;
  logic [PC_W-1:0]      o_pc_q, o_pc_d;

  logic                 accept;
  dec_t                 dec;
  op_e                  op;
  logic [CELL_BITS-1:0] cell_val;
  logic [SD_W-1:0]      sd_m1;
  logic [PC_W-1:0]      pc_inc;

  assign in_i.ready = (state_q == S_IDLE) && (!ov_q || out_o.ready);
  assign accept     = in_i.valid && in_i.ready;

  assign dec      = decode_char(in_i.prog_char);
  assign op       = op_e'(prog_rdata_i);
  assign cell_val = tape_rdata_i;
  assign sd_m1    = sd_q - SD_W'(1);
  assign pc_inc   = pc_q + PC_W'(1);

  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    cnt_d     = cnt_q;
    pc_d      = pc_q;
    dp_d      = dp_q;
    sd_d      = sd_q;
    skip_d    = skip_q;
    err_d     = err_q;
    inval_d   = inval_q;
    ov_d      = ov_q && !out_o.ready;
    o_outv_d  = o_outv_q;
    o_val_d   = o_val_q;
    o_taken_d = o_taken_q;
    o_stat_d  = o_stat_q;
    o_pc_d    = o_pc_q;

    // Reads run every cycle from the current registers; the data lines up
    // with the execute cycle that follows an accepted step.
    prog_o.we    = 1'b0;
    prog_o.waddr = cnt_q[PROG_AW-1:0];
    prog_o.wdata = dec.op;
    prog_o.raddr = pc_q[PROG_AW-1:0];
    tape_o.we    = 1'b0;
    tape_o.waddr = dp_q;
    tape_o.wdata = '0;
    tape_o.raddr = dp_q;
    stk_o.we     = 1'b0;
    stk_o.waddr  = sd_q[STK_AW-1:0];
    stk_o.wdata  = pc_q[PROG_AW-1:0];
    stk_o.raddr  = sd_m1[STK_AW-1:0];

    unique case (state_q)
      S_CLEAR: begin
        tape_o.we    = 1'b1;
        tape_o.waddr = clr_q;
        clr_d        = clr_q + TAPE_AW'(1);
        if (clr_q == TAPE_AW'(TAPE_DEPTH - 1)) begin
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        if (accept) begin
          inval_d   = in_i.in_value;
          o_outv_d  = 1'b0;
          o_val_d   = '0;
          o_taken_d = 1'b0;
          o_pc_d    = pc_q;
          if (in_i.req_type == REQ_LOAD) begin
            ov_d     = 1'b1;
            o_stat_d = err_q;
            if (dec.hit) begin
              if (cnt_q < PC_W'(PROG_DEPTH)) begin
                prog_o.we = 1'b1;
                cnt_d     = cnt_q + PC_W'(1);
              end else begin
                o_stat_d = STAT_FULL;
              end
            end
          end else if (err_q != STAT_OK) begin
            ov_d     = 1'b1;
            o_stat_d = err_q;
          end else if (pc_q >= cnt_q) begin
            ov_d     = 1'b1;
            err_d    = STAT_HALT;
            o_stat_d = STAT_HALT;
          end else begin
            state_d = S_EXEC;
          end
        end
      end

      S_EXEC: begin
        state_d   = S_IDLE;
        o_outv_d  = 1'b0;
        o_val_d   = '0;
        o_taken_d = 1'b0;
        if (skip_q != '0) begin
          if (op == OP_OPEN) begin
            skip_d = skip_q + PC_W'(1);
          end else if (op == OP_CLOSE) begin
            skip_d = skip_q - PC_W'(1);
          end
          pc_d = pc_inc;
        end else begin
          case (op)
            OP_RIGHT: begin
              dp_d = (dp_q == TAPE_AW'(TAPE_DEPTH - 1)) ? '0 : dp_q + TAPE_AW'(1);
              pc_d = pc_inc;
            end
            OP_LEFT: begin
              dp_d = (dp_q == '0) ? TAPE_AW'(TAPE_DEPTH - 1) : dp_q - TAPE_AW'(1);
              pc_d = pc_inc;
            end
            OP_PLUS: begin
              tape_o.we    = 1'b1;
              tape_o.wdata = cell_val + CELL_BITS'(1);
              pc_d         = pc_inc;
            end
            OP_MINUS: begin
              tape_o.we    = 1'b1;
              tape_o.wdata = cell_val - CELL_BITS'(1);
              pc_d         = pc_inc;
            end
            OP_OUT: begin
              o_outv_d = 1'b1;
              o_val_d  = cell_val[CHAR_W-1:0];
              pc_d     = pc_inc;
            end
            OP_IN: begin
              tape_o.we    = 1'b1;
              tape_o.wdata = CELL_BITS'(inval_q);
              o_taken_d    = 1'b1;
              pc_d         = pc_inc;
            end
            OP_OPEN: begin
              if (cell_val == '0) begin
                skip_d = PC_W'(1);
                pc_d   = pc_inc;
              end else if (sd_q >= SD_W'(STACK_DEPTH)) begin
                err_d = STAT_OVERFLOW;
              end else begin
                stk_o.we = 1'b1;
                sd_d     = sd_q + SD_W'(1);
                pc_d     = pc_inc;
              end
            end
            default: begin
              if (sd_q == '0) begin
                err_d = STAT_UNMATCHED;
              end else if (cell_val != '0) begin
                // Jump back to the instruction just after the matching open.
                pc_d = PC_W'(stk_rdata_i) + PC_W'(1);
              end else begin
                sd_d = sd_m1;
                pc_d = pc_inc;
              end
            end
          endcase
        end
        if (err_d == STAT_OK && pc_d >= cnt_q) begin
          err_d = STAT_HALT;
        end
        ov_d     = 1'b1;
        o_stat_d = err_d;
        o_pc_d   = pc_d;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      cnt_q   <= '0;
      pc_q    <= '0;
      dp_q    <= '0;
      sd_q    <= '0;
      skip_q  <= '0;
      err_q   <= STAT_OK;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      cnt_q   <= cnt_d;
      pc_q    <= pc_d;
      dp_q    <= dp_d;
      sd_q    <= sd_d;
      skip_q  <= skip_d;
      err_q   <= err_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    inval_q   <= inval_d;
    o_outv_q  <= o_outv_d;
    o_val_q   <= o_val_d;
    o_taken_q <= o_taken_d;
    o_stat_q  <= o_stat_d;
    o_pc_q    <= o_pc_d;
  end

  assign out_o.valid     = ov_q;
  assign out_o.out_valid = o_outv_q;
  assign out_o.out_value = o_val_q;
  assign out_o.in_taken  = o_taken_q;
  assign out_o.status    = o_stat_q;
  assign out_o.pc_now    = o_pc_q;

endmodule

@@ design/brainfuck_processor_unit.sv @@
// ----------------------------------------------------------------------------
// brainfuck_processor_unit
// Brainfuck processor with a program load port and single-step execution.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries one request per valid/ready transfer. req_type 0 appends
//   prog_char to program memory (non-command characters are dropped);
//   req_type 1 executes the instruction at the program counter, and
//   in_value is stored to the current cell only by ','.
//   out_o returns exactly one result per request, in request order, with
//   the output byte, the input-consumed flag, status and the program counter.
//   Loads, and steps refused by a halt or an error, are answered in the
//   cycle after acceptance; an executed step adds the execute state
//   (program, tape and loop stack are read on acceptance, the cell and
//   stack are written back in execute). One request is in flight at a time.
//   A result sits in an output register; the next request is taken in the
//   same cycle as the pending result is taken. While out_o stalls, in_i
//   stays not ready.
//   After reset the tape is cleared one cell per cycle, all 32768 cells, and
//   in_i is not ready until that pass is done. Program and loop stack
//   memories are not cleared; halt and error status stay until reset.
// ----------------------------------------------------------------------------
module brainfuck_processor_unit (
  input  logic      clk_i,
  input  logic      rst_ni,
  bfp_in_if.sink    in_i,
  bfp_out_if.source out_o
);
  import bfp_pkg::*;

  prog_port_t           prog_p;
  tape_port_t           tape_p;
  stk_port_t            stk_p;
  logic [OP_W-1:0]      prog_rdata;
  logic [CELL_BITS-1:0] tape_rdata;
  logic [PROG_AW-1:0]   stk_rdata;

  bfp_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .out_o        (out_o),
    .prog_o       (prog_p),
    .prog_rdata_i (prog_rdata),
    .tape_o       (tape_p),
    .tape_rdata_i (tape_rdata),
    .stk_o        (stk_p),
    .stk_rdata_i  (stk_rdata)
  );

  bfp_ram #(.WIDTH(OP_W), .DEPTH(PROG_DEPTH)) u_prog_ram (
    .clk_i   (clk_i),
    .we_i    (prog_p.we),
    .waddr_i (prog_p.waddr),
    .wdata_i (prog_p.wdata),
    .raddr_i (prog_p.raddr),
    .rdata_o (prog_rdata)
  );

  bfp_ram #(.WIDTH(CELL_BITS), .DEPTH(TAPE_DEPTH)) u_tape_ram (
    .clk_i   (clk_i),
    .we_i    (tape_p.we),
    .waddr_i (tape_p.waddr),
    .wdata_i (tape_p.wdata),
    .raddr_i (tape_p.raddr),
    .rdata_o (tape_rdata)
  );

  bfp_ram #(.WIDTH(PROG_AW), .DEPTH(STACK_DEPTH)) u_stk_ram (
    .clk_i   (clk_i),
    .we_i    (stk_p.we),
    .waddr_i (stk_p.waddr),
    .wdata_i (stk_p.wdata),
    .raddr_i (stk_p.raddr),
    .rdata_o (stk_rdata)
  );

`ifndef SYNTHESIS
  // A program write happens only for an accepted load request.
  a_prog_we_on_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    prog_p.we |-> (in_i.valid && in_i.ready && (in_i.req_type == REQ_LOAD)))
    else $error("program write without a load request");

  // A push to the loop stack never coincides with a cell write.
  a_stk_tape_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stk_p.we |-> !tape_p.we)
    else $error("stack push together with a tape write");

  // One instruction cannot both print and consume input.
  a_out_in_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> !(out_o.out_valid && out_o.in_taken))
    else $error("result both outputs and consumes a byte");

  // Consuming input means the instruction executed without error.
  a_taken_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.in_taken) |->
      ((out_o.status == STAT_OK) || (out_o.status == STAT_HALT)))
    else $error("input consumed with an error status");
`endif

endmodule

@@ dv/bfp_tb_pkg.sv @@
// ----------------------------------------------------------------------------
// bfp_tb_pkg
// Result checker for the Brainfuck processor testbench. It runs its own copy
// of the program store, tape, loop stack and status for every accepted
// request and compares each returned result with the one it predicted.
// ----------------------------------------------------------------------------
package bfp_tb_pkg;
  import bfp_pkg::*;

  typedef struct {
    logic              out_valid;
    logic [CHAR_W-1:0] out_value;
    logic              in_taken;
    logic [STAT_W-1:0] status;
    logic [PC_W-1:0]   pc_now;
  } bfp_result_t;

  class bfp_step_checker;
    op_e                  prog_mem [PROG_DEPTH];
    logic [PC_W-1:0]      prog_count;
    logic [CELL_BITS-1:0] tape [TAPE_DEPTH];
    logic [PC_W-1:0]      pc;
    logic [TAPE_AW-1:0]   dp;
    logic [PROG_AW-1:0]   loop_pc [STACK_DEPTH];
    int unsigned          open_loops;
    int unsigned          skip_level;
    status_e              err;
    int unsigned          mismatches;
    bfp_result_t          due_results [$];

    function new();
      foreach (tape[i]) tape[i] = '0;
      prog_count = '0;
      pc         = '0;
      dp         = '0;
      open_loops = 0;
      skip_level = 0;
      err        = STAT_OK;
      mismatches = 0;
    endfunction

    function bit decode(input logic [CHAR_W-1:0] c, output op_e op);
      op = OP_RIGHT;
      case (c)
        CH_RIGHT: op = OP_RIGHT;
        CH_LEFT:  op = OP_LEFT;
        CH_PLUS:  op = OP_PLUS;
        CH_MINUS: op = OP_MINUS;
        CH_OUT:   op = OP_OUT;
        CH_IN:    op = OP_IN;
        CH_OPEN:  op = OP_OPEN;
        CH_CLOSE: op = OP_CLOSE;
        default:  return 1'b0;
      endcase
      return 1'b1;
    endfunction

    // True when the next instruction is ',' that loads the counter of a loop.
    function bit at_loop_counter();
      if (err != STAT_OK || skip_level != 0 || 32'(pc) + 1 >= 32'(prog_count)) return 1'b0;
      return prog_mem[pc[PROG_AW-1:0]] == OP_IN &&
             prog_mem[pc[PROG_AW-1:0] + PROG_AW'(1)] == OP_OPEN;
    endfunction

    function void run_step(input logic [CHAR_W-1:0] inval, inout bfp_result_t r);
      logic [CELL_BITS-1:0] cell_val;
      op_e                  op;
      cell_val = tape[dp];
      if (err != STAT_OK) return;
      if (pc >= prog_count) begin
        err = STAT_HALT;
        return;
      end
      op = prog_mem[pc[PROG_AW-1:0]];
      if (skip_level != 0) begin
        if (op == OP_OPEN) skip_level++;
        else if (op == OP_CLOSE) skip_level--;
        pc = pc + PC_W'(1);
      end else begin
        case (op)
          OP_RIGHT: begin
            dp = (dp == TAPE_AW'(TAPE_DEPTH - 1)) ? '0 : dp + TAPE_AW'(1);
            pc = pc + PC_W'(1);
          end
          OP_LEFT: begin
            dp = (dp == '0) ? TAPE_AW'(TAPE_DEPTH - 1) : dp - TAPE_AW'(1);
            pc = pc + PC_W'(1);
          end
          OP_PLUS: begin
            tape[dp] = cell_val + CELL_BITS'(1);
            pc = pc + PC_W'(1);
          end
          OP_MINUS: begin
            tape[dp] = cell_val - CELL_BITS'(1);
            pc = pc + PC_W'(1);
          end
          OP_OUT: begin
            r.out_valid = 1'b1;
            r.out_value = cell_val;
            pc = pc + PC_W'(1);
          end
          OP_IN: begin
            tape[dp] = inval;
            r.in_taken = 1'b1;
            pc = pc + PC_W'(1);
          end
          OP_OPEN: begin
            if (cell_val == '0) begin
              skip_level = 1;
              pc = pc + PC_W'(1);
            end else if (open_loops >= STACK_DEPTH) begin
              err = STAT_OVERFLOW;
            end else begin
              loop_pc[open_loops] = pc[PROG_AW-1:0];
              open_loops++;
              pc = pc + PC_W'(1);
            end
          end
          default: begin
            if (open_loops == 0) begin
              err = STAT_UNMATCHED;
            end else if (cell_val != '0) begin
              pc = PC_W'(loop_pc[open_loops-1]) + PC_W'(1);
            end else begin
              open_loops--;
              pc = pc + PC_W'(1);
            end
          end
        endcase
      end
      if (err == STAT_OK && pc >= prog_count) err = STAT_HALT;
    endfunction

    function void note_request(req_e kind, logic [CHAR_W-1:0] ch,
                               logic [CHAR_W-1:0] inval);
      bfp_result_t r;
      op_e         op;
      r.out_valid = 1'b0;
      r.out_value = '0;
      r.in_taken  = 1'b0;
      if (kind == REQ_LOAD) begin
        r.status = err;
        if (decode(ch, op)) begin
          if (prog_count < PROG_DEPTH) begin
            prog_mem[prog_count[PROG_AW-1:0]] = op;
            prog_count = prog_count + PC_W'(1);
          end else begin
            // A full store drops the character and flags only this request.
            r.status = STAT_FULL;
          end
        end
      end else begin
        run_step(inval, r);
        r.status = err;
      end
      r.pc_now = pc;
      due_results.insert(due_results.size(), r);
    endfunction

    function void compare_field(string name, logic [PC_W-1:0] want,
                                logic [PC_W-1:0] seen);
      if (seen !== want) begin
        $error("%s: expected %0d, got %0d", name, want, seen);
        mismatches++;
      end
    endfunction

    function void check_result(bfp_result_t got);
      bfp_result_t want;
      if (due_results.size() == 0) begin
        $error("result arrived with no request outstanding");
        mismatches++;
        return;
      end
      want = due_results.pop_front();
      compare_field("out_valid", PC_W'(want.out_valid), PC_W'(got.out_valid));
      compare_field("out_value", PC_W'(want.out_value), PC_W'(got.out_value));
      compare_field("in_taken", PC_W'(want.in_taken), PC_W'(got.in_taken));
      compare_field("status", PC_W'(want.status), PC_W'(got.status));
      compare_field("pc_now", want.pc_now, got.pc_now);
    endfunction

    function int unsigned pending();
      return due_results.size();
    endfunction
  endclass

endpackage

@@ dv/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Drives program loads and single steps into the Brainfuck processor and
// checks every result against the checker's own execution of the program.
// Loops are built so that they always end, which keeps execution moving.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import bfp_pkg::*;
  import bfp_tb_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 320;
  localparam int unsigned CYCLE_LIMIT  = 600000;
  localparam int unsigned HOLD_AT      = 150;
  localparam int unsigned HOLD_CYCLES  = 300;

  // The first six are the commands without brackets.
  localparam logic [CHAR_W-1:0] ALL_OPS [8] = '{CH_RIGHT, CH_LEFT, CH_PLUS, CH_MINUS,
                                                CH_OUT, CH_IN, CH_OPEN, CH_CLOSE};
  localparam logic [CHAR_W-1:0] CELL_OPS [4] = '{CH_PLUS, CH_MINUS, CH_IN, CH_OUT};

  logic clk_i;
  logic rst_ni;

  bfp_in_if  req_if ();
  bfp_out_if res_if ();

  brainfuck_processor_unit i_dut (
    .clk_i,
    .rst_ni,
    .in_i  (req_if),
    .out_o (res_if)
  );

  bfp_step_checker sb = new();

  int unsigned cycles       = 0;
  int unsigned results_seen = 0;
  int unsigned burst_left   = 0;
  int unsigned random_items = 0;
  int unsigned loop_floor   = 0;
  int unsigned hold_left    = 0;
  int unsigned mode         = 0;
  int unsigned mode_left    = 0;
  bit          hold_done    = 1'b0;

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Result side: check what was taken at this edge, then pick the next ready.
  always @(posedge clk_i) begin
    bfp_result_t got;
    if (res_if.valid && res_if.ready) begin
      got.out_valid = res_if.out_valid;
      got.out_value = res_if.out_value;
      got.in_taken  = res_if.in_taken;
      got.status    = res_if.status;
      got.pc_now    = res_if.pc_now;
      sb.check_result(got);
      results_seen++;
    end
    if (hold_left != 0) begin
      hold_left--;
      res_if.ready <= 1'b0;
    end else if (!hold_done && results_seen >= HOLD_AT) begin
      // One long hold-off so the block backs up into its request port.
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      res_if.ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(16, 160);
      end else begin
        mode_left--;
      end
      case (mode)
        0:       res_if.ready <= 1'b1;
        1:       res_if.ready <= 1'($urandom_range(0, 1));
        2:       res_if.ready <= (cycles % 3) != 0;
        default: res_if.ready <= $urandom_range(0, 7) == 0;
      endcase
    end
  end

  task automatic send(req_e kind, logic [CHAR_W-1:0] ch, logic [CHAR_W-1:0] inval);
    int unsigned gap;
    op_e         op;
    req_if.valid     <= 1'b1;
    req_if.req_type  <= kind;
    req_if.prog_char <= ch;
    req_if.in_value  <= inval;
    do @(posedge clk_i); while (!req_if.ready);
    sb.note_request(kind, ch, inval);
    if (kind == REQ_STEP || sb.decode(ch, op)) random_items++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 8);
      gap = $urandom_range(1, 6);
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic load_char(logic [CHAR_W-1:0] ch);
    send(REQ_LOAD, ch, CHAR_W'($urandom_range(0, 255)));
  endtask

  task automatic load_code(logic [CHAR_W-1:0] code [$]);
    foreach (code[i]) load_char(code[i]);
  endtask

  // Loop counters get small values so loops finish within a few passes.
  task automatic step_once();
    logic [CHAR_W-1:0] inval;
    if (sb.at_loop_counter()) inval = CHAR_W'($urandom_range(loop_floor, 3));
    else inval = CHAR_W'($urandom_range(0, 255));
    send(REQ_STEP, CHAR_W'($urandom_range(0, 255)), inval);
  endtask

  // Never step onto the last loaded instruction, so the end is not reached.
  task automatic step_ahead(int unsigned budget);
    while (budget > 0 && sb.err == STAT_OK && 32'(sb.pc) + 1 < 32'(sb.prog_count)) begin
      step_once();
      budget--;
    end
  endtask

  task automatic step_until_error(int unsigned budget);
    while (budget > 0 && sb.err == STAT_OK) begin
      step_once();
      budget--;
    end
  endtask

  function automatic logic [CHAR_W-1:0] noise_char();
    logic [CHAR_W-1:0] c;
    op_e               op;
    do c = CHAR_W'($urandom_range(0, 255)); while (sb.decode(c, op));
    return c;
  endfunction

  // Loop "[-...]" whose body writes only cells to the right of its counter,
  // so the counter drops by one per pass and the loop always ends.
  function automatic void add_loop(ref logic [CHAR_W-1:0] q [$], input int unsigned level);
    int unsigned n;
    q.insert(q.size(), CH_OPEN);
    q.insert(q.size(), CH_MINUS);
    n = $urandom_range(1, 4);
    repeat (n) begin
      case ($urandom_range(0, 4))
        0: q.insert(q.size(), CH_OUT);
        1, 2: begin
          q.insert(q.size(), CH_RIGHT);
          q.insert(q.size(), CELL_OPS[$urandom_range(0, 3)]);
          q.insert(q.size(), CH_LEFT);
        end
        default: begin
          q.insert(q.size(), CH_RIGHT);
          if (level != 0) begin
            q.insert(q.size(), CH_IN);
            add_loop(q, level - 1);
          end else begin
            q.insert(q.size(), CH_PLUS);
          end
          q.insert(q.size(), CH_LEFT);
        end
      endcase
    end
    q.insert(q.size(), CH_CLOSE);
  endfunction

  initial begin
    int unsigned       variant;
    logic [CHAR_W-1:0] code [$];
    rst_ni           = 1'b0;
    req_if.valid     = 1'b0;
    req_if.req_type  = REQ_LOAD;
    req_if.prog_char = '0;
    req_if.in_value  = '0;
    res_if.ready     = 1'b0;
    // Only one terminal condition fits in a run; the seed picks which one.
    variant = $urandom_range(0, 7);
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // A step on an empty program halts at once and stays halted.
    if (variant == 7) step_once();
    load_char(8'h00);
    load_char(8'hFF);
    load_char(8'h41);
    // Pointer wraps both ways, cell wraps both ways, input, and a skipped loop.
    code = '{CH_LEFT, CH_RIGHT, CH_MINUS, CH_OUT, CH_PLUS, CH_OUT,
             CH_IN, CH_OUT, CH_OPEN, CH_PLUS, CH_CLOSE, CH_RIGHT};
    load_code(code);
    repeat (11) send(REQ_STEP, CHAR_W'($urandom_range(0, 255)), 8'h00);

    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      code.delete();
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          code.insert(code.size(), CH_IN);
          add_loop(code, $urandom_range(0, 2));
        end
        4, 5, 6: repeat ($urandom_range(1, 8))
          code.insert(code.size(), ALL_OPS[$urandom_range(0, 5)]);
        default: repeat ($urandom_range(1, 3)) code.insert(code.size(), noise_char());
      endcase
      load_code(code);
      step_ahead($urandom_range(1, 24));
    end

    step_ahead(60);
    code.delete();
    case (variant)
      3, 4: begin
        // More nested opens on a nonzero cell than the loop stack holds.
        loop_floor = 1;
        code.insert(code.size(), CH_IN);
        repeat (STACK_DEPTH + 1) code.insert(code.size(), CH_OPEN);
      end
      5, 6: code = '{CH_PLUS, CH_CLOSE};
      default: ;
    endcase
    load_code(code);
    step_until_error(120);

    // Once stopped, steps are refused and loads are still taken.
    repeat (2) step_once();
    load_char(ALL_OPS[$urandom_range(0, 5)]);
    load_char(noise_char());
    load_char(CH_OPEN);
    load_char(CH_CLOSE);
    load_char(noise_char());
    load_char(ALL_OPS[$urandom_range(0, 5)]);
    repeat (2) step_once();

    req_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
design/bfp_pkg.sv
design/bfp_if.sv
design/bfp_ram.sv
design/bfp_ctrl.sv
design/brainfuck_processor_unit.sv
dv/bfp_tb_pkg.sv
dv/testbench.sv
